[hw/rtl/jsd_pkg.sv]
// ----------------------------------------------------------------------------
// jsd_pkg: shared types and constants for the joystick stepper drive
// Holds the mode and sequencer encodings, the configuration bundle, the
// controller command and status groups and the half-step coil table.
// ----------------------------------------------------------------------------
package jsd_pkg;

  localparam int SAMPLE_W     = 10;
  localparam int INTERVAL_W   = 8;
  localparam int PHASE_COUNT  = 8;
  localparam int PHASE_W      = $clog2(PHASE_COUNT);
  localparam int COIL_W       = 4;
  localparam int ADDR_W       = 5;
  localparam int DATA_W       = 32;

  // Divider geometry: |x-a|*|d-c| fits in 18 bits, |b-a| in 10 bits.
  localparam int NUM_W        = 18;
  localparam int DEN_W        = SAMPLE_W;
  localparam int DIV_STEPS    = NUM_W;
  localparam int DIV_CNT_W    = $clog2(DIV_STEPS);

  localparam logic [SAMPLE_W-1:0]   UP_THRESHOLD_RST  = 10'd700;
  localparam logic [SAMPLE_W-1:0]   DOWN_THRESHOLD_RST = 10'd300;
  localparam logic [SAMPLE_W-1:0]   UP_FULL_SCALE_RST = 10'd825;
  localparam logic [INTERVAL_W-1:0] FASTEST_RST       = 8'd2;
  localparam logic [INTERVAL_W-1:0] SLOWEST_RST       = 8'd30;

  typedef enum logic [2:0] {
    REG_UP_THRESHOLD   = 3'd0,
    REG_DOWN_THRESHOLD = 3'd1,
    REG_UP_FULL_SCALE  = 3'd2,
    REG_FASTEST        = 3'd3,
    REG_SLOWEST        = 3'd4
  } reg_index_t;

  typedef enum logic [1:0] {
    MODE_HALT = 2'd0,
    MODE_UP   = 2'd1,
    MODE_DOWN = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_PREP = 2'd1,
    S_DIV  = 2'd2,
    S_DONE = 2'd3
  } seq_state_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0]   up_threshold;
    logic [SAMPLE_W-1:0]   down_threshold;
    logic [SAMPLE_W-1:0]   up_full_scale;
    logic [INTERVAL_W-1:0] fastest_interval;
    logic [INTERVAL_W-1:0] slowest_interval;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic prep;
    logic div_step;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_busy;
  } ctrl_sts_t;

  function automatic logic [COIL_W-1:0] half_step(input logic [PHASE_W-1:0] idx);
    logic [COIL_W-1:0] pat;
    case (idx)
      3'd0:    pat = 4'b0001;
      3'd1:    pat = 4'b0011;
      3'd2:    pat = 4'b0010;
      3'd3:    pat = 4'b0110;
      3'd4:    pat = 4'b0100;
      3'd5:    pat = 4'b1100;
      3'd6:    pat = 4'b1000;
      3'd7:    pat = 4'b1001;
      default: pat = 4'b0000;
    endcase
    return pat;
  endfunction

endpackage

[hw/rtl/joystick_stepper_drive_unit.sv]
// ----------------------------------------------------------------------------
// joystick_stepper_drive_unit: half-step stepper speed control from a joystick
// Takes one joystick sample per request, runs the halt/up/down mode machine,
// maps the sample to a step interval and emits one coil result per request.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                                   Direction  Handshake
//  --------  ----------------------------------------  ---------  ---------------
//  input     joystick_sample                           in         in_valid/in_ready
//  output    coil_pattern, step_taken, drive_mode,     out        out_valid/out_ready
//            reverse_alarm
//  config    psel, penable, pwrite, paddr, pwdata,     in/out     APB, pready high
//            prdata, pready
//
// Each request runs from acceptance to a valid result in order: the mode is
// settled and the product (x-a)*(d-c) formed, the one-bit-per-cycle restoring
// divider runs, and the mapped interval is applied to the step counters. The
// sequencer is ready again as soon as the result is registered, so it takes
// no new request before the last one is done. The result waits in the output
// register while out_ready is low, and the sequencer holds in its final state
// until the register frees up. Reset (rst, synchronous, active high) restores
// the register defaults and the motor state, and clears all handshake state.
//
module joystick_stepper_drive_unit
  import jsd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // Sample request channel.
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [SAMPLE_W-1:0]   joystick_sample,
  // Result channel.
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [COIL_W-1:0]     coil_pattern,
  output logic                  step_taken,
  output logic [1:0]            drive_mode,
  output logic                  reverse_alarm,
  // Configuration port.
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_W-1:0]     paddr,
  input  logic [DATA_W-1:0]     pwdata,
  output logic [DATA_W-1:0]     prdata,
  output logic                  pready
);

  cfg_t       cfg;
  ctrl_cmd_t  cmd;
  ctrl_sts_t  sts;
  reg_index_t reg_sel;
  logic       cfg_write;

  // The registers sit at word addresses, so the low two address bits are
  // ignored and the next three select the register.
  assign pready    = 1'b1;
  assign reg_sel   = reg_index_t'(paddr[4:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.up_threshold     <= UP_THRESHOLD_RST;
      cfg.down_threshold   <= DOWN_THRESHOLD_RST;
      cfg.up_full_scale    <= UP_FULL_SCALE_RST;
      cfg.fastest_interval <= FASTEST_RST;
      cfg.slowest_interval <= SLOWEST_RST;
    end else if (cfg_write) begin
      case (reg_sel)
        REG_UP_THRESHOLD:   cfg.up_threshold     <= pwdata[SAMPLE_W-1:0];
        REG_DOWN_THRESHOLD: cfg.down_threshold   <= pwdata[SAMPLE_W-1:0];
        REG_UP_FULL_SCALE:  cfg.up_full_scale    <= pwdata[SAMPLE_W-1:0];
        REG_FASTEST:        cfg.fastest_interval <= pwdata[INTERVAL_W-1:0];
        REG_SLOWEST:        cfg.slowest_interval <= pwdata[INTERVAL_W-1:0];
        default: ;
      endcase
    end
  end

  // Reads of addresses past the register list return zero.
  always_comb begin
    case (reg_sel)
      REG_UP_THRESHOLD:   prdata = DATA_W'(cfg.up_threshold);
      REG_DOWN_THRESHOLD: prdata = DATA_W'(cfg.down_threshold);
      REG_UP_FULL_SCALE:  prdata = DATA_W'(cfg.up_full_scale);
      REG_FASTEST:        prdata = DATA_W'(cfg.fastest_interval);
      REG_SLOWEST:        prdata = DATA_W'(cfg.slowest_interval);
      default:            prdata = '0;
    endcase
  end

  // The sequencer owns the handshake on the input side and paces the divider.
  jsd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath keeps the motor state and owns the output register.
  jsd_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .cmd             (cmd),
    .sts             (sts),
    .joystick_sample (joystick_sample),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .coil_pattern    (coil_pattern),
    .step_taken      (step_taken),
    .drive_mode      (drive_mode),
    .reverse_alarm   (reverse_alarm)
  );

endmodule

[hw/rtl/jsd_ctrl.sv]
// ----------------------------------------------------------------------------
// jsd_ctrl: sequencer for the joystick stepper drive
// Steps each request through load, mapping setup, the serial divide and the
// final state update, and issues the matching commands to the datapath.
// ----------------------------------------------------------------------------
module jsd_ctrl
  import jsd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  ctrl_sts_t sts,
  output ctrl_cmd_t cmd
);

  seq_state_t           state;
  seq_state_t           state_next;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic                 div_last;

  assign div_last = (div_cnt == DIV_CNT_W'(DIV_STEPS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      div_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == S_DIV) begin
        div_cnt <= div_cnt + 1'b1;
      end else begin
        div_cnt <= '0;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_PREP;
      end
      S_PREP: state_next = S_DIV;
      S_DIV: begin
        if (div_last) state_next = S_DONE;
      end
      S_DONE: begin
        if (!sts.out_busy) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_PREP: cmd.prep = 1'b1;
      S_DIV:  cmd.div_step = 1'b1;
      S_DONE: cmd.commit = !sts.out_busy;
      default: cmd = '0;
    endcase
  end

endmodule

[hw/rtl/jsd_dp.sv]
// ----------------------------------------------------------------------------
// jsd_dp: datapath for the joystick stepper drive
// Holds the mode, counters, phase and coil state, the linear map with its
// multiplier and restoring divider, and the output register.
// ----------------------------------------------------------------------------
module jsd_dp
  import jsd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  cfg_t                  cfg,
  input  ctrl_cmd_t             cmd,
  output ctrl_sts_t             sts,
  input  logic [SAMPLE_W-1:0]   joystick_sample,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [COIL_W-1:0]     coil_pattern,
  output logic                  step_taken,
  output logic [1:0]            drive_mode,
  output logic                  reverse_alarm
);

  logic [SAMPLE_W-1:0]   sample;
  mode_t                 mode;
  mode_t                 mode_next;
  logic                  alarm_flag;
  logic                  alarm_next;
  logic [PHASE_W-1:0]    phase_index;
  logic [INTERVAL_W-1:0] up_countdown;
  logic [INTERVAL_W-1:0] down_count;
  logic [COIL_W-1:0]     held_pattern;

  // Mapping setup.
  logic                  sel_up;
  logic [SAMPLE_W-1:0]   map_a;
  logic [SAMPLE_W-1:0]   map_b;
  logic signed [SAMPLE_W:0]   diff_x;
  logic signed [INTERVAL_W:0] diff_d;
  logic signed [SAMPLE_W:0]   span;
  logic signed [19:0]         prod;
  logic signed [19:0]         prod_abs;

  // Divider registers and the trial compare.
  logic [NUM_W-1:0]      quo;
  logic [DEN_W-1:0]      rem;
  logic [DEN_W-1:0]      den;
  logic                  neg;
  logic                  span_zero;
  logic [DEN_W:0]        trial;
  logic                  trial_ge;

  // Commit logic.
  logic signed [19:0]    q_signed;
  logic signed [19:0]    r_sum;
  logic [INTERVAL_W-1:0] mapped;
  logic [INTERVAL_W-1:0] cd_dec;
  logic [INTERVAL_W-1:0] dc_inc;

  always_comb begin
    mode_next  = mode;
    alarm_next = alarm_flag;
    case (mode)
      MODE_HALT: begin
        if (sample > cfg.up_threshold) begin
          mode_next = MODE_UP;
        end else if (sample < cfg.down_threshold) begin
          mode_next  = MODE_DOWN;
          alarm_next = 1'b1;
        end
      end
      MODE_UP: begin
        if (sample < cfg.up_threshold) mode_next = MODE_HALT;
      end
      MODE_DOWN: begin
        if (sample > cfg.down_threshold) begin
          mode_next  = MODE_HALT;
          alarm_next = 1'b0;
        end
      end
      default: begin
        mode_next  = MODE_HALT;
        alarm_next = 1'b0;
      end
    endcase
  end

  assign sel_up   = (mode_next == MODE_UP);
  assign map_a    = sel_up ? cfg.up_threshold : '0;
  assign map_b    = sel_up ? cfg.up_full_scale : cfg.down_threshold;
  assign diff_x   = $signed({1'b0, sample}) - $signed({1'b0, map_a});
  assign diff_d   = $signed({1'b0, cfg.slowest_interval})
                  - $signed({1'b0, cfg.fastest_interval});
  assign span     = $signed({1'b0, map_b}) - $signed({1'b0, map_a});
  assign prod     = 20'(diff_x * diff_d);
  assign prod_abs = prod[19] ? -prod : prod;

  assign trial    = {rem, quo[NUM_W-1]};
  assign trial_ge = (trial >= {1'b0, den});

  assign q_signed = neg ? -$signed({2'b00, quo}) : $signed({2'b00, quo});
  assign r_sum    = q_signed + $signed({12'd0, cfg.fastest_interval});

  always_comb begin
    if (span_zero) begin
      mapped = cfg.slowest_interval;
    end else if (r_sum[19]) begin
      mapped = '0;
    end else if (r_sum > 20'sd255) begin
      mapped = '1;
    end else begin
      mapped = r_sum[INTERVAL_W-1:0];
    end
  end

  assign cd_dec = up_countdown - 1'b1;
  assign dc_inc = down_count + 1'b1;

  assign sts.out_busy = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_HALT;
      alarm_flag   <= 1'b0;
      phase_index  <= '0;
      up_countdown <= SLOWEST_RST;
      down_count   <= '0;
      held_pattern <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (out_ready) out_valid <= 1'b0;
      if (cmd.prep) begin
        mode       <= mode_next;
        alarm_flag <= alarm_next;
      end
      if (cmd.commit) begin
        out_valid     <= 1'b1;
        if (mode == MODE_UP) begin
          if (cd_dec <= mapped) begin
            held_pattern <= half_step(phase_index);
            phase_index  <= phase_index - 1'b1;
            up_countdown <= cfg.slowest_interval;
          end else begin
            up_countdown <= cd_dec;
          end
        end else if (mode == MODE_DOWN) begin
          if (dc_inc >= mapped) begin
            held_pattern <= half_step(phase_index);
            phase_index  <= phase_index + 1'b1;
            down_count   <= '0;
          end else begin
            down_count <= dc_inc;
          end
        end
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    if (cmd.load) sample <= joystick_sample;
    if (cmd.prep) begin
      quo       <= prod_abs[NUM_W-1:0];
      rem       <= '0;
      den       <= span[SAMPLE_W] ? DEN_W'(-span) : span[DEN_W-1:0];
      // The quotient is negative when the product and the span differ in sign.
      neg       <= prod[19] ^ span[SAMPLE_W];
      span_zero <= (span == '0);
    end else if (cmd.div_step) begin
      rem <= trial_ge ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
      quo <= {quo[NUM_W-2:0], trial_ge};
    end
    if (cmd.commit) begin
      drive_mode    <= mode;
      reverse_alarm <= alarm_flag;
      if (mode == MODE_UP) begin
        step_taken   <= (cd_dec <= mapped);
        coil_pattern <= (cd_dec <= mapped) ? half_step(phase_index) : held_pattern;
      end else if (mode == MODE_DOWN) begin
        step_taken   <= (dc_inc >= mapped);
        coil_pattern <= (dc_inc >= mapped) ? half_step(phase_index) : held_pattern;
      end else begin
        step_taken   <= 1'b0;
        coil_pattern <= held_pattern;
      end
    end
  end

endmodule

[hw/rtl/jsd_checker.sv]
// ----------------------------------------------------------------------------
// jsd_checker: port-level checks for the joystick stepper drive
// Watches the result channel for stall stability and mode, alarm and step consistency.
// ----------------------------------------------------------------------------
module jsd_checker
  import jsd_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_ready,
  input logic [COIL_W-1:0] coil_pattern,
  input logic              step_taken,
  input logic [1:0]        drive_mode,
  input logic              reverse_alarm
);

  // A stalled result keeps its contents.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(coil_pattern)
      && $stable(step_taken) && $stable(drive_mode) && $stable(reverse_alarm))
    else $error("result changed while stalled");

  // The alarm tracks the down mode exactly.
  a_alarm: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (reverse_alarm == (drive_mode == MODE_DOWN)))
    else $error("reverse alarm disagrees with drive mode");

  // No step is ever taken while halted.
  a_halt: assert property (@(posedge clk) disable iff (rst)
    out_valid && (drive_mode == MODE_HALT) |-> !step_taken)
    else $error("step reported in halt mode");

  // A step always drives one coil or a pair of coils.
  a_coil: assert property (@(posedge clk) disable iff (rst)
    out_valid && step_taken |->
      ($countones(coil_pattern) == 1 || $countones(coil_pattern) == 2))
    else $error("invalid coil pattern on a step");

endmodule

bind joystick_stepper_drive_unit jsd_checker u_jsd_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .coil_pattern  (coil_pattern),
  .step_taken    (step_taken),
  .drive_mode    (drive_mode),
  .reverse_alarm (reverse_alarm)
);
